### rtl/nbh_pkg.sv
// Package for the NMEA baud rate hunter: sizes, register indexes, character codes.
package nbh_pkg;

	localparam int MAX_CHUNK  = 511;
	localparam int RATE_COUNT = 4;
	localparam int RATE_SLOTS = 4;
	localparam int CHUNK_W    = $clog2(MAX_CHUNK + 1);
	localparam int PROD_W     = CHUNK_W + 3;
	localparam int RATE_W     = 22;
	localparam int INTERVAL_W = 16;
	localparam int IDX_W      = 2;
	localparam int CFG_IDX_W  = 3;

	typedef logic [RATE_W-1:0]     rate_t;
	typedef logic [INTERVAL_W-1:0] interval_t;
	typedef logic [CHUNK_W-1:0]    chunk_cnt_t;
	typedef logic [IDX_W-1:0]      rate_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL   = 3'd0,
		REG_RATE_ZERO  = 3'd1,
		REG_RATE_ONE   = 3'd2,
		REG_RATE_TWO   = 3'd3,
		REG_RATE_THREE = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;

	localparam interval_t INTERVAL_RESET = 16'd3000;
	localparam interval_t SILENCE_TOP    = '1;
	localparam rate_t RATE_RESET [RATE_SLOTS] = '{22'd115200, 22'd9600, 22'd38400, 22'd57600};

	function automatic logic is_printable(input logic [7:0] b);
		return (b == CH_CR) || (b == CH_LF) || ((b >= PRINT_LO) && (b <= PRINT_HI));
	endfunction

endpackage

### rtl/nmea_baud_rate_hunter.sv
// NMEA baud rate hunter: chunk judging, silence timer and baud rate rotation.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while out_ready allows; an input register and the result register
// let one more request enter while a result waits to be taken.
// Reset (arst_n low): chunk counts, silence count and rate index clear, registers
// return to 3000 ticks and rates 115200, 9600, 38400, 57600.
module nmea_baud_rate_hunter
	import nbh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [7:0]           rx_byte,
	input  logic                 chunk_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RATE_W-1:0]    sel_rate,
	output logic [IDX_W-1:0]     rate_index,
	output logic                 reprobe,
	output logic                 chunk_done,
	output logic                 nmea_seen,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data
);

	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	interval_t  interval_q;
	rate_t      rate_q [RATE_SLOTS];

	chunk_cnt_t chunk_len_q, print_q;
	logic       dollar_q, pend_q, conf_q;
	interval_t  silence_q;
	rate_idx_t  index_q;

	logic       out_valid_q;
	rate_t      baud_q;
	rate_idx_t  rate_index_q;
	logic       reprobe_q, done_q, seen_q;

	logic       advance, fire;

	chunk_cnt_t len_n, print_n;
	logic       dollar_n, pend_n, conf_n;
	interval_t  silence_n;
	rate_idx_t  index_n;
	logic       reprobe_n, done_n, seen_n;
	logic [PROD_W-1:0] print_x5, len_x4;
	interval_t  sil_inc;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op_t'(operation);
			byte_s1 <= rx_byte;
			end_s1  <= chunk_end;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			for (int i = 0; i < RATE_SLOTS; i++) begin
				rate_q[i] <= RATE_RESET[i];
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INTERVAL:   interval_q <= cfg_data[INTERVAL_W-1:0];
				REG_RATE_ZERO:  rate_q[0]  <= cfg_data;
				REG_RATE_ONE:   rate_q[1]  <= cfg_data;
				REG_RATE_TWO:   rate_q[2]  <= cfg_data;
				REG_RATE_THREE: rate_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state for the request in the input register
	always_comb begin
		len_n     = chunk_len_q;
		print_n   = print_q;
		dollar_n  = dollar_q;
		pend_n    = pend_q;
		conf_n    = conf_q;
		silence_n = silence_q;
		index_n   = index_q;
		reprobe_n = 1'b0;
		done_n    = 1'b0;
		seen_n    = 1'b0;
		print_x5  = '0;
		len_x4    = '0;
		sil_inc   = silence_q;

		if (op_s1 == OP_BYTE) begin
			if (chunk_len_q < CHUNK_W'(MAX_CHUNK)) begin
				len_n = chunk_len_q + 1'b1;
			end
			if (is_printable(byte_s1) && (print_q < CHUNK_W'(MAX_CHUNK))) begin
				print_n = print_q + 1'b1;
			end
			if (pend_q) begin
				conf_n = 1'b1;
			end
			if (dollar_q && ((byte_s1 == CH_G) || (byte_s1 == CH_P))) begin
				pend_n = 1'b1;
			end
			dollar_n = (byte_s1 == CH_DOLLAR);

			print_x5 = PROD_W'(print_n) * PROD_W'(5);
			len_x4   = PROD_W'(len_n) << 2;

			if (end_s1) begin
				done_n = 1'b1;
				seen_n = conf_n && (print_x5 >= len_x4);
				if (seen_n) begin
					silence_n = '0;
				end
				len_n    = '0;
				print_n  = '0;
				dollar_n = 1'b0;
				pend_n   = 1'b0;
				conf_n   = 1'b0;
			end
		end else begin
			if (silence_q != SILENCE_TOP) begin
				sil_inc = silence_q + 1'b1;
			end
			silence_n = sil_inc;
			if (sil_inc >= interval_q) begin
				index_n   = (index_q == IDX_W'(RATE_COUNT - 1)) ? '0 : index_q + 1'b1;
				silence_n = '0;
				reprobe_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_len_q <= '0;
			print_q     <= '0;
			dollar_q    <= 1'b0;
			pend_q      <= 1'b0;
			conf_q      <= 1'b0;
			silence_q   <= '0;
			index_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				chunk_len_q <= len_n;
				print_q     <= print_n;
				dollar_q    <= dollar_n;
				pend_q      <= pend_n;
				conf_q      <= conf_n;
				silence_q   <= silence_n;
				index_q     <= index_n;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			baud_q       <= rate_q[index_n];
			rate_index_q <= index_n;
			reprobe_q    <= reprobe_n;
			done_q       <= done_n;
			seen_q       <= seen_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign sel_rate   = baud_q;
	assign rate_index = rate_index_q;
	assign reprobe    = reprobe_q;
	assign chunk_done = done_q;
	assign nmea_seen  = seen_q;

	a_seen_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!nmea_seen || chunk_done))
		else $error("verdict without a closed chunk");

	a_tick_or_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reprobe && chunk_done))
		else $error("result marks both a switch and a closed chunk");

	a_print_bound: assert property (@(posedge clk) disable iff (!arst_n)
		print_q <= chunk_len_q)
		else $error("printable count above chunk length");

	a_switch_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && reprobe_n) |=> (index_q != $past(index_q)) && (silence_q == '0))
		else $error("rate switch did not advance index or clear silence");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the NMEA baud rate hunter: verdicts, silence timer, rotation.
module tb_top;
	import nbh_pkg::*;

	typedef struct packed {
		rate_t     baud;
		rate_idx_t idx;
		logic      reprobe;
		logic      done;
		logic      seen;
	} hunt_result_t;

	class rate_hunt_scoreboard;
		interval_t    interval;
		rate_t        rates [RATE_SLOTS];
		int unsigned  chunk_len;
		int unsigned  print_cnt;
		bit           after_dollar;
		bit           pair_wait;
		bit           pair_ok;
		interval_t    silence;
		rate_idx_t    sel;
		hunt_result_t pending [$];
		int           errors;
		int           requests;
		int           chunks;
		int           candidates;
		int           switches;
		int           writes;

		function void clear_chunk();
			chunk_len    = 0;
			print_cnt    = 0;
			after_dollar = 0;
			pair_wait    = 0;
			pair_ok      = 0;
		endfunction

		function void reset_all();
			interval = INTERVAL_RESET;
			foreach (rates[i])
				rates[i] = RATE_RESET[i];
			clear_chunk();
			silence = '0;
			sel     = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, rate_t data);
			writes++;
			if (idx == REG_INTERVAL)
				interval = data[INTERVAL_W-1:0];
			else if (idx >= REG_RATE_ZERO && idx <= REG_RATE_THREE)
				rates[idx - REG_RATE_ZERO] = data;
		endfunction

		function void note_request(op_t op, logic [7:0] b, logic last);
			hunt_result_t r;
			bit           printable;
			r = '0;
			if (op == OP_BYTE) begin
				printable = (b == CH_CR) || (b == CH_LF) || (b >= PRINT_LO && b <= PRINT_HI);
				if (chunk_len < MAX_CHUNK)
					chunk_len++;
				if (printable && print_cnt < MAX_CHUNK)
					print_cnt++;
				if (pair_wait)
					pair_ok = 1;
				if (after_dollar && (b == CH_G || b == CH_P))
					pair_wait = 1;
				after_dollar = (b == CH_DOLLAR);
				if (last) begin
					r.done = 1;
					r.seen = pair_ok && (print_cnt * 5 >= chunk_len * 4);
					chunks++;
					if (r.seen) begin
						silence = '0;
						candidates++;
					end
					clear_chunk();
				end
			end else begin
				if (silence != SILENCE_TOP)
					silence++;
				if (silence >= interval) begin
					sel       = (sel == RATE_COUNT - 1) ? '0 : sel + 1'b1;
					silence   = '0;
					r.reprobe = 1;
					switches++;
				end
			end
			r.baud = rates[sel];
			r.idx  = sel;
			pending.push_back(r);
			requests++;
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(hunt_result_t got);
			hunt_result_t want;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: sel_rate %0d rate_index %0d",
					got.baud, got.idx);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("sel_rate", 32'(want.baud), 32'(got.baud));
			compare("rate_index", 32'(want.idx), 32'(got.idx));
			compare("reprobe", 32'(want.reprobe), 32'(got.reprobe));
			compare("chunk_done", 32'(want.done), 32'(got.done));
			compare("nmea_seen", 32'(want.seen), 32'(got.seen));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 operation;
	logic [7:0]           rx_byte;
	logic                 chunk_end;
	logic                 out_valid;
	logic                 out_ready;
	logic [RATE_W-1:0]    sel_rate;
	logic [IDX_W-1:0]     rate_index;
	logic                 reprobe;
	logic                 chunk_done;
	logic                 nmea_seen;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_data;

	bit                   idle_on = 1;
	rate_hunt_scoreboard  sb = new();

	nmea_baud_rate_hunter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.chunk_end  (chunk_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sel_rate   (sel_rate),
		.rate_index (rate_index),
		.reprobe    (reprobe),
		.chunk_done (chunk_done),
		.nmea_seen  (nmea_seen),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#24000000;
		$display("FAIL nmea_baud_rate_hunter");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 15);
		if (r < 12)
			return $urandom_range(1, 3);
		else if (r < 15)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(hunt_result_t'{sel_rate, rate_index, reprobe, chunk_done,
					nmea_seen});
			if (stall > 0) begin
				stall--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (idle_on && $urandom_range(0, 5) == 0)
					stall = gap_len();
			end
		end
	end

	task automatic send_request(op_t op, logic [7:0] b, logic last);
		int gap;
		in_valid  <= 1;
		operation <= op;
		rx_byte   <= b;
		chunk_end <= last;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(op, b, last);
		gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// rx_byte and chunk_end carry junk on ticks
	task automatic send_tick();
		send_request(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_chunk(logic [7:0] q [$], int tick_pct);
		foreach (q[i]) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_tick();
			send_request(OP_BYTE, q[i], i == q.size() - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, rate_t data);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic set_rates(rate_t r0, rate_t r1, rate_t r2, rate_t r3);
		write_reg(REG_RATE_ZERO, r0);
		write_reg(REG_RATE_ONE, r1);
		write_reg(REG_RATE_TWO, r2);
		write_reg(REG_RATE_THREE, r3);
	endtask

	function automatic logic [7:0] text_byte(int junk_pct);
		if ($urandom_range(0, 99) < junk_pct)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(PRINT_LO, PRINT_HI));
	endfunction

	task automatic random_chunk(int tick_pct);
		logic [7:0] q [$];
		int         kind;
		int         junk;
		kind = $urandom_range(0, 37);
		junk = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
		if (kind < 26) begin
			repeat ($urandom_range(1, 2)) begin
				q.push_back(CH_DOLLAR);
				q.push_back($urandom_range(0, 1) ? CH_G : CH_P);
				repeat ($urandom_range(0, 20))
					q.push_back(text_byte(junk));
				if ($urandom_range(0, 3) != 0) begin
					q.push_back(CH_CR);
					q.push_back(CH_LF);
				end
			end
		end else if (kind < 32) begin
			repeat ($urandom_range(1, 12))
				q.push_back(8'($urandom_range(0, 255)));
		end else begin
			// broken header: lone dollar, pair at the very end, or a wrong talker letter
			repeat ($urandom_range(0, 4))
				q.push_back(text_byte(junk));
			q.push_back(CH_DOLLAR);
			case ($urandom_range(0, 2))
				0: ;
				1: q.push_back($urandom_range(0, 1) ? CH_G : CH_P);
				default: begin
					q.push_back(text_byte(50));
					q.push_back(text_byte(junk));
				end
			endcase
		end
		send_chunk(q, tick_pct);
	endtask

	// long chunk, counts saturate
	task automatic long_chunk(int tick_pct);
		logic [7:0] q [$];
		if ($urandom_range(0, 2) != 0) begin
			q.push_back(CH_DOLLAR);
			q.push_back(CH_G);
		end
		repeat ($urandom_range(512, 525))
			q.push_back(text_byte($urandom_range(0, 1) ? 2 : 22));
		send_chunk(q, tick_pct);
	endtask

	task automatic random_phase(int count, int tick_pct);
		int start;
		int burst;
		start = sb.requests;
		while (sb.requests - start < count) begin
			if ($urandom_range(0, 15) == 0)
				idle_on = !idle_on;
			if ($urandom_range(0, 4) == 0) begin
				burst = (sb.interval <= 40) ? sb.interval + 2 : 8;
				repeat ($urandom_range(1, burst))
					send_tick();
			end else begin
				random_chunk(tick_pct);
			end
		end
		drain();
	endtask

	initial begin
		arst_n    = 0;
		in_valid  = 0;
		operation = OP_BYTE;
		rx_byte   = '0;
		chunk_end = 0;
		out_ready = 0;
		cfg_we    = 0;
		cfg_index = REG_INTERVAL;
		cfg_data  = '0;
		sb.reset_all();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values; printable edges; pair and ratio corner cases
		send_chunk('{CH_DOLLAR, CH_G, 8'h00, 8'hFF, 8'h1F, 8'h7F, PRINT_LO, PRINT_HI, CH_CR,
			CH_LF}, 0);
		send_chunk('{CH_DOLLAR, CH_P, 8'h2C}, 0);
		send_chunk('{CH_DOLLAR, CH_G}, 0);
		send_chunk('{CH_DOLLAR, CH_DOLLAR, CH_G, 8'h41}, 0);
		send_chunk('{CH_DOLLAR, CH_G, CH_P, 8'h41, 8'h00}, 0);
		send_request(OP_TICK, 8'hFF, 1);
		drain();

		// interval written with bits above its width; rate extremes
		write_reg(REG_INTERVAL, 22'h3F0003);
		set_rates(22'd300, 22'd4000000, 22'h3FFFFF, 22'd1200);
		// rate switch in the middle of a chunk keeps the partial counts
		send_request(OP_BYTE, CH_DOLLAR, 0);
		send_request(OP_BYTE, CH_G, 0);
		repeat (3) send_tick();
		send_request(OP_BYTE, CH_P, 1);
		random_phase(50, 10);

		// out-of-range indexes are ignored; interval zero switches on every tick
		for (int k = REG_RATE_THREE + 1; k < 2 ** CFG_IDX_W; k++)
			write_reg(k[CFG_IDX_W-1:0], rate_t'($urandom()));
		write_reg(REG_INTERVAL, 22'h010000);
		random_phase(40, 5);

		write_reg(REG_INTERVAL, 22'd1);
		set_rates(rate_t'($urandom_range(300, 4000000)), 22'd115200, 22'd9600,
			rate_t'($urandom_range(300, 4000000)));
		random_phase(40, 5);

		write_reg(REG_INTERVAL, 22'd25);
		set_rates(rate_t'($urandom_range(300, 4000000)), rate_t'($urandom_range(300, 4000000)),
			rate_t'($urandom_range(300, 4000000)), rate_t'($urandom_range(300, 4000000)));
		random_phase(60, 15);
		long_chunk(2);
		drain();

		// widest interval
		write_reg(REG_INTERVAL, 22'h00FFFF);
		random_phase(40, 5);

		write_reg(REG_INTERVAL, 22'(INTERVAL_RESET));
		set_rates(22'd57600, 22'd38400, 22'd4000000, 22'd300);
		random_phase(40, 10);

		$display("Run covered %0d requests: %0d chunks, %0d NMEA candidates, %0d rate switches",
			sb.requests, sb.chunks, sb.candidates, sb.switches);
		$display("Config: %0d register writes, intervals 0, 1, 3, 25, 3000 and 65535",
			sb.writes);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS nmea_baud_rate_hunter");
		else
			$display("FAIL nmea_baud_rate_hunter");
		$finish;
	end

endmodule

### sim.f
rtl/nbh_pkg.sv
rtl/nmea_baud_rate_hunter.sv
tb/tb_top.sv
